@@ sv/assert_macros.svh @@
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked also during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/dcms_pkg.sv @@
// ----------------------------------------------------------------------------
// dcms_pkg
// Types and constants shared by the decaying count-min rate sketch.
// ----------------------------------------------------------------------------
package dcms_pkg;

  localparam int unsigned CountW = 32;
  localparam int unsigned RateW = 28;
  localparam int unsigned SizeW = 11;
  localparam int unsigned HashW = 5;
  localparam logic [SizeW-1:0] SizeReset = 11'd1024;
  localparam logic [HashW-1:0] HashReset = 5'd4;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic {
    CFG_TABLE_SIZE = 1'b0,
    CFG_HASH_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MODA,
    ST_MODB,
    ST_RD,
    ST_RDW,
    ST_RDC,
    ST_SUM,
    ST_WR_RD,
    ST_WR_W,
    ST_WR_C,
    ST_RATE,
    ST_RATE2,
    ST_OUT,
    ST_TK_RD,
    ST_TK_W,
    ST_TK_WR
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic mod_start;  // start both modulo reductions
    logic ptr_init;   // bucket pointer to start, visit count to zero
    logic ptr_step;   // advance bucket pointer by stride
    logic ptr_lin;    // advance bucket pointer by one (tick walk)
    logic ptr_zero;   // bucket pointer to zero
    logic rd;         // read bucket at pointer
    logic min_upd;    // fold read data into minimum
    logic sum;        // saturating add of increment
    logic wr_raise;   // write new value if bucket is below it
    logic wr_decay;   // write decayed bucket
    logic wr_clear;   // write zero at pointer
    logic rate1;      // first rate stage
    logic rate2;      // second rate stage
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mod_done;
    logic last_visit;  // pointer at last visit of this add
    logic last_entry;  // pointer at last bucket in use
    logic clr_last;    // pointer at last bucket of memory
  } sts_t;

  function automatic logic [CountW-1:0] decay(input logic [CountW-1:0] x);
    decay = {1'b0, x[CountW-1:1]} + {2'b00, x[CountW-1:2]};
  endfunction

endpackage

@@ sv/dcms_ram.sv @@
// ----------------------------------------------------------------------------
// dcms_ram
// Two-port style RAM with one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dcms_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/dcms_mod.sv @@
// ----------------------------------------------------------------------------
// dcms_mod
// Restoring divider remainder: two 32-bit values mod a size, one bit a cycle.
// ----------------------------------------------------------------------------
module dcms_mod #(
  parameter int unsigned AddrW = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [31:0]      a_i,
  input  logic [31:0]      b_i,
  input  logic [AddrW:0]   m_i,
  output logic             done_o,
  output logic [AddrW-1:0] ra_o,
  output logic [AddrW-1:0] rb_o
);

  logic [31:0]    a_q, a_d, b_q, b_d;
  logic [AddrW:0] ra_q, ra_d, rb_q, rb_d;
  logic [5:0]     cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic [AddrW+1:0] ta, tb;

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    ra_d = ra_q;
    rb_d = rb_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    ta = {ra_q, a_q[31]};
    tb = {rb_q, b_q[31]};
    if (start_i) begin
      a_d = a_i;
      b_d = b_i;
      ra_d = '0;
      rb_d = '0;
      cnt_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      a_d = {a_q[30:0], 1'b0};
      b_d = {b_q[30:0], 1'b0};
      ra_d = (ta >= {1'b0, m_i}) ? (AddrW+1)'(ta - {1'b0, m_i}) : ta[AddrW:0];
      rb_d = (tb >= {1'b0, m_i}) ? (AddrW+1)'(tb - {1'b0, m_i}) : tb[AddrW:0];
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    ra_q <= ra_d;
    rb_q <= rb_d;
  end

  assign done_o = !busy_q;
  assign ra_o = ra_q[AddrW-1:0];
  assign rb_o = rb_q[AddrW-1:0];

endmodule

@@ sv/dcms_datapath.sv @@
// ----------------------------------------------------------------------------
// dcms_datapath
// Bucket memory, pointer walk, minimum, saturating add and rate divide.
// ----------------------------------------------------------------------------
module dcms_datapath #(
  parameter int unsigned TableDepth = 1024,
  parameter int unsigned MaxHashes = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dcms_pkg::cmd_t         cmd_i,
  output dcms_pkg::sts_t         sts_o,
  input  logic [31:0]            hash_first_i,
  input  logic [31:0]            hash_step_i,
  input  logic [31:0]            increment_i,
  input  logic [$clog2(TableDepth):0] size_i,
  input  logic [$clog2(MaxHashes+1)-1:0] nhash_i,
  output logic [dcms_pkg::RateW-1:0] rate_o
);
  import dcms_pkg::*;

  localparam int unsigned AddrW = $clog2(TableDepth);
  localparam int unsigned NW = $clog2(MaxHashes + 1);

  logic [31:0]      hf_q, hs_q, inc_q;
  logic [AddrW-1:0] ptr_q, ptr_d, start, stride;
  logic [NW-1:0]    vis_q, vis_d;
  logic [CountW-1:0] min_q, min_d, rdata, wdata;
  logic [AddrW:0]   nxt;
  logic             we, mod_done;
  logic [CountW:0]  sum;
  logic [CountW-1:0] diff_q;
  logic [63:0]      prod;
  logic [RateW-1:0] rate_q;

  dcms_mod #(.AddrW(AddrW)) u_mod (
    .clk_i, .rst_ni,
    .start_i(cmd_i.mod_start),
    .a_i(hf_q), .b_i(hs_q), .m_i(size_i),
    .done_o(mod_done), .ra_o(start), .rb_o(stride)
  );

  dcms_ram #(.Width(CountW), .Depth(TableDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(ptr_q), .wdata_i(wdata),
    .raddr_i(ptr_q), .rdata_o(rdata)
  );

  assign nxt = {1'b0, ptr_q} + {1'b0, stride};
  assign sum = {1'b0, min_q} + {1'b0, inc_q};

  always_comb begin
    ptr_d = ptr_q;
    vis_d = vis_q;
    if (cmd_i.ptr_init) begin
      ptr_d = start;
      vis_d = '0;
    end else if (cmd_i.ptr_step) begin
      ptr_d = (nxt >= size_i) ? AddrW'(nxt - size_i) : nxt[AddrW-1:0];
      vis_d = vis_q + NW'(1);
    end else if (cmd_i.ptr_lin) begin
      ptr_d = ptr_q + AddrW'(1);
    end else if (cmd_i.ptr_zero) begin
      ptr_d = '0;
    end
    min_d = min_q;
    // the last read folds in even while the pointer rewinds for the raise pass
    if (cmd_i.min_upd) begin
      if (rdata < min_q) begin
        min_d = rdata;
      end
    end else if (cmd_i.ptr_init) begin
      min_d = '1;
    end else if (cmd_i.sum) begin
      min_d = sum[CountW] ? '1 : sum[CountW-1:0];
    end
    we = cmd_i.wr_clear || cmd_i.wr_decay || (cmd_i.wr_raise && rdata < min_q);
    priority if (cmd_i.wr_clear) begin
      wdata = '0;
    end else if (cmd_i.wr_decay) begin
      wdata = decay(rdata);
    end else begin
      wdata = min_q;
    end
  end

  // divide by 5 through reciprocal 0xCCCCCCCD >> 34
  assign prod = diff_q * 64'hCCCC_CCCD;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      vis_q <= '0;
    end else begin
      ptr_q <= ptr_d;
      vis_q <= vis_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hf_q <= hash_first_i;
      hs_q <= hash_step_i;
      inc_q <= increment_i;
    end
    min_q <= min_d;
    if (cmd_i.rate1) begin
      diff_q <= min_q - decay(min_q);
    end
    if (cmd_i.rate2) begin
      rate_q <= prod[34+RateW-1:34];
    end
  end

  assign rate_o = rate_q;
  assign sts_o.mod_done = mod_done;
  assign sts_o.last_visit = (vis_q == nhash_i - NW'(1));
  assign sts_o.last_entry = ({1'b0, ptr_q} == size_i - (AddrW+1)'(1));
  assign sts_o.clr_last = (ptr_q == AddrW'(TableDepth - 1));

endmodule

@@ sv/dcms_ctrl.sv @@
// ----------------------------------------------------------------------------
// dcms_ctrl
// Sequencer for clear, add and tick passes and the handshakes.
// ----------------------------------------------------------------------------
module dcms_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           op_i,
  output logic           out_valid,
  input  logic           out_stall,
  input  dcms_pkg::sts_t sts_i,
  output dcms_pkg::cmd_t cmd_o
);
  import dcms_pkg::*;
  `include "assert_macros.svh"

  state_e st_q, st_d;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_CLEAR: if (sts_i.clr_last) st_d = ST_IDLE;
      ST_IDLE: if (in_valid) st_d = (op_e'(op_i) == OP_TICK) ? ST_TK_RD : ST_MODA;
      ST_MODA: st_d = ST_MODB;
      ST_MODB: if (sts_i.mod_done) st_d = ST_RD;
      ST_RD: st_d = ST_RDW;
      ST_RDW: st_d = ST_RDC;
      ST_RDC: st_d = sts_i.last_visit ? ST_SUM : ST_RD;
      ST_SUM: st_d = ST_WR_RD;
      ST_WR_RD: st_d = ST_WR_W;
      ST_WR_W: st_d = ST_WR_C;
      ST_WR_C: st_d = sts_i.last_visit ? ST_RATE : ST_WR_RD;
      ST_RATE: st_d = ST_RATE2;
      ST_RATE2: st_d = ST_OUT;
      ST_OUT: if (!out_stall) st_d = ST_IDLE;
      ST_TK_RD: st_d = ST_TK_W;
      ST_TK_W: st_d = ST_TK_WR;
      ST_TK_WR: st_d = sts_i.last_entry ? ST_IDLE : ST_TK_RD;
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall = (st_q != ST_IDLE);
    out_valid = (st_q == ST_OUT);
    unique case (st_q)
      ST_CLEAR: begin
        cmd_o.wr_clear = 1'b1;
        cmd_o.ptr_lin = 1'b1;
      end
      ST_IDLE: begin
        cmd_o.load = in_valid;
        cmd_o.ptr_zero = 1'b1;
      end
      ST_MODA: cmd_o.mod_start = 1'b1;
      ST_MODB: cmd_o.ptr_init = sts_i.mod_done;
      ST_RDC: begin
        cmd_o.min_upd = 1'b1;
        cmd_o.ptr_step = !sts_i.last_visit;
        cmd_o.ptr_init = sts_i.last_visit;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
      end
      ST_WR_C: begin
        cmd_o.wr_raise = 1'b1;
        cmd_o.ptr_step = 1'b1;
      end
      ST_RATE: cmd_o.rate1 = 1'b1;
      ST_RATE2: cmd_o.rate2 = 1'b1;
      ST_TK_WR: begin
        cmd_o.wr_decay = 1'b1;
        cmd_o.ptr_lin = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR;
    end else begin
      st_q <= st_d;
    end
  end

  `ASSERT_CLK(a_out_only_after_rate, clk_i, rst_ni,
    (st_q == ST_OUT) |-> ($past(st_q) == ST_RATE2 || $past(st_q) == ST_OUT),
    "result without rate stage")
  `ASSERT_CLK(a_no_double_write, clk_i, rst_ni,
    !(cmd_o.wr_clear && cmd_o.wr_decay), "conflicting writes")
  `ASSERT_ALWAYS(a_reset_clear, clk_i,
    !rst_ni |=> (st_q == ST_CLEAR || !rst_ni), "reset must start clear pass")

endmodule

@@ sv/decaying_count_min_rate_sketch.sv @@
// ----------------------------------------------------------------------------
// decaying_count_min_rate_sketch
// Count-min rate sketch with conservative update and periodic decay.
// ----------------------------------------------------------------------------
// After reset a clearing pass writes zero to all TABLE_DEPTH buckets, one a
// cycle, before the first item is taken. One item is worked on at a time. An
// add first runs the bit-serial modulo of both hashes, then reads each hashed
// bucket and walks them again to raise them, paced by the registered read of
// the single bucket memory, and last computes the rate. A tick walks every
// bucket in use through the same memory port and decays it.
module decaying_count_min_rate_sketch #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned MAX_HASHES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation_i,
  input  logic [31:0] hash_first_i,
  input  logic [31:0] hash_step_i,
  input  logic [31:0] increment_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [dcms_pkg::RateW-1:0] rate_o,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [dcms_pkg::SizeW-1:0] cfg_wdata
);
  import dcms_pkg::*;

  localparam int unsigned AddrW = $clog2(TABLE_DEPTH);
  localparam int unsigned NW = $clog2(MAX_HASHES + 1);

  logic [SizeW-1:0] size_q;
  logic [HashW-1:0] hcnt_q;
  logic [AddrW:0]   size_eff;
  logic [NW-1:0]    nhash_eff;
  cmd_t cmd;
  sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeReset;
      hcnt_q <= HashReset;
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_TABLE_SIZE: size_q <= cfg_wdata;
        CFG_HASH_COUNT: hcnt_q <= cfg_wdata[HashW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (size_q == '0) begin
      size_eff = (AddrW+1)'(1);
    end else if (32'(size_q) > TABLE_DEPTH) begin
      size_eff = (AddrW+1)'(TABLE_DEPTH);
    end else begin
      size_eff = (AddrW+1)'(size_q);
    end
    if (hcnt_q == '0) begin
      nhash_eff = NW'(1);
    end else if (32'(hcnt_q) > MAX_HASHES) begin
      nhash_eff = NW'(MAX_HASHES);
    end else begin
      nhash_eff = NW'(hcnt_q);
    end
  end

  dcms_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .op_i(operation_i),
    .out_valid, .out_stall, .sts_i(sts), .cmd_o(cmd)
  );

  dcms_datapath #(.TableDepth(TABLE_DEPTH), .MaxHashes(MAX_HASHES)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .hash_first_i, .hash_step_i, .increment_i,
    .size_i(size_eff), .nhash_i(nhash_eff), .rate_o
  );

endmodule
